FILE: rtl/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

    // memory depth, a power of two so that addresses wrap by masking
    localparam int MEM_WORDS_DEF = 1024;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_J     = 6'h02;

    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2a;

    typedef enum logic [9:0] {
        ST_FETCH  = 10'b00_0000_0001,
        ST_DECODE = 10'b00_0000_0010,
        ST_ADDR   = 10'b00_0000_0100,
        ST_MEMRD  = 10'b00_0000_1000,
        ST_LWB    = 10'b00_0001_0000,
        ST_MEMWR  = 10'b00_0010_0000,
        ST_EXEC   = 10'b00_0100_0000,
        ST_RWB    = 10'b00_1000_0000,
        ST_BRANCH = 10'b01_0000_0000,
        ST_JUMP   = 10'b10_0000_0000
    } state_t;

    // architectural registers seen by the access stage
    typedef struct packed {
        state_t      fsm;
        logic        halt;
        logic [31:0] ir;
        logic [31:0] mdr;
        logic [31:0] opb;
        logic [31:0] alu;
    } arch_t;

    function automatic logic [3:0] state_num(input state_t s);
        logic [3:0] n;
        case (s)
            ST_FETCH:  n = 4'd0;
            ST_DECODE: n = 4'd1;
            ST_ADDR:   n = 4'd2;
            ST_MEMRD:  n = 4'd3;
            ST_LWB:    n = 4'd4;
            ST_MEMWR:  n = 4'd5;
            ST_EXEC:   n = 4'd6;
            ST_RWB:    n = 4'd7;
            ST_BRANCH: n = 4'd8;
            ST_JUMP:   n = 4'd9;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] sext16(input logic [31:0] ir);
        return {{16{ir[15]}}, ir[15:0]};
    endfunction

    function automatic logic [31:0] alu_func(input logic [31:0] a, input logic [31:0] b,
                                             input logic [5:0] funct);
        logic [31:0] r;
        case (funct)
            FN_ADD:  r = a + b;
            FN_SUB:  r = a - b;
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            FN_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/mrc_main_mem.sv
`timescale 1ns / 1ps

module mrc_main_mem #(
    parameter int MEM_WORDS = 1024,
    parameter int ADDR_W    = 10
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [31:0]       wdata,
    output logic [31:0]       rdata
);

    logic [31:0] ram [MEM_WORDS];
    logic [31:0] rdata_reg;

    // single port, one access a cycle, read data registered
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                ram[addr] <= wdata;
            end else begin
                rdata_reg <= ram[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mrc_regfile.sv
`timescale 1ns / 1ps

module mrc_regfile (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        re,
    input  logic [4:0]  ra,
    input  logic [4:0]  rb,
    input  logic        we,
    input  logic [4:0]  wa,
    input  logic [31:0] wd,
    output logic [31:0] rd_a,
    output logic [31:0] rd_b
);

    logic [31:0] ram [32];
    logic [31:0] valid_reg;
    logic [31:0] valid_next;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        av_reg;
    logic        bv_reg;

    // entries never written read as zero; register zero is never written
    always_comb begin
        valid_next = valid_reg;
        if (we) begin
            valid_next[wa] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (re) begin
                av_reg <= valid_reg[ra];
                bv_reg <= valid_reg[rb];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            ram[wa] <= wd;
        end
        if (re) begin
            a_reg <= ram[ra];
            b_reg <= ram[rb];
        end
    end

    assign rd_a = av_reg ? a_reg : 32'd0;
    assign rd_b = bv_reg ? b_reg : 32'd0;

endmodule

FILE: rtl/mrc_datapath.sv
`timescale 1ns / 1ps

module mrc_datapath #(
    parameter int ADDR_W = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               commit,
    input  logic               active,
    input  logic [31:0]        mem_rdata,
    input  logic [31:0]        rf_a,
    input  logic [31:0]        rf_b,
    output mrc_pkg::arch_t     eff,
    output logic [ADDR_W-1:0]  eff_pc
);

    import mrc_pkg::*;

    arch_t             arch_reg;
    arch_t             arch_next;
    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] pc_next;
    logic [31:0]       opa_reg;
    logic [31:0]       opa_next;
    logic [5:0]        op;
    logic [31:0]       pc_ext;

    assign op     = arch_reg.ir[31:26];
    assign pc_ext = {{(32 - ADDR_W){1'b0}}, pc_reg};

    always_comb begin
        arch_next = arch_reg;
        pc_next   = pc_reg;
        opa_next  = opa_reg;
        if (active) begin
            case (arch_reg.fsm)
                ST_FETCH: begin
                    arch_next.ir  = mem_rdata;
                    arch_next.mdr = mem_rdata;
                    pc_next       = pc_reg + 1'b1;
                    if (mem_rdata == 32'd0) begin
                        arch_next.halt = 1'b1;
                        arch_next.fsm  = ST_FETCH;
                    end else begin
                        arch_next.fsm  = ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    opa_next      = rf_a;
                    arch_next.opb = rf_b;
                    arch_next.alu = pc_ext + sext16(arch_reg.ir);
                    if (op == OP_RTYPE) begin
                        arch_next.fsm = ST_EXEC;
                    end else if (op == OP_LW || op == OP_SW) begin
                        arch_next.fsm = ST_ADDR;
                    end else if (op == OP_BEQ) begin
                        arch_next.fsm = ST_BRANCH;
                    end else if (op == OP_J) begin
                        arch_next.fsm = ST_JUMP;
                    end else begin
                        arch_next.fsm = ST_FETCH;
                    end
                end
                ST_ADDR: begin
                    arch_next.alu = opa_reg + sext16(arch_reg.ir);
                    arch_next.fsm = (op == OP_LW) ? ST_MEMRD : ST_MEMWR;
                end
                ST_MEMRD: begin
                    arch_next.mdr = mem_rdata;
                    arch_next.fsm = ST_LWB;
                end
                ST_EXEC: begin
                    arch_next.alu = alu_func(opa_reg, arch_reg.opb, arch_reg.ir[5:0]);
                    arch_next.fsm = ST_RWB;
                end
                ST_BRANCH: begin
                    if (opa_reg == arch_reg.opb) begin
                        pc_next = arch_reg.alu[ADDR_W-1:0];
                    end
                    arch_next.fsm = ST_FETCH;
                end
                ST_JUMP: begin
                    pc_next       = arch_reg.ir[ADDR_W-1:0];
                    arch_next.fsm = ST_FETCH;
                end
                // write-back and store states act in the access stage
                default: begin
                    arch_next.fsm = ST_FETCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg.fsm  <= ST_FETCH;
            arch_reg.halt <= 1'b0;
            arch_reg.ir   <= '0;
            arch_reg.mdr  <= '0;
            arch_reg.opb  <= '0;
            arch_reg.alu  <= '0;
            pc_reg        <= '0;
            opa_reg       <= '0;
        end else if (commit) begin
            arch_reg <= arch_next;
            pc_reg   <= pc_next;
            opa_reg  <= opa_next;
        end
    end

    // state as the next beat must see it
    assign eff    = commit ? arch_next : arch_reg;
    assign eff_pc = commit ? pc_next : pc_reg;

endmodule

FILE: rtl/multicycle_risc_core.sv
`timescale 1ns / 1ps

// multicycle core for a small load/store instruction subset
// s_ channel: one beat is either a memory load (s_tuser = 0) that writes
// load_word at load_address, or a controller tick (s_tuser = 1) that moves
// the ten-state controller on by one state
// m_ channel: exactly one result beat per input beat, in order, carrying the
// state, pc and halt flag after the beat plus any register write or store
// each accepted beat is registered in the update stage, then in the output register
// throughput: one beat per cycle, sustained while m_tready stays high; the access
// stage uses the memory port and register file in the cycle of acceptance, the
// update stage folds the read data into the architectural registers on commit
// back-to-back ticks see the update stage's next values, so no bubbles
// reset: synchronous, active low; pc, controller, halt flag and register
// file valid bits clear at once, no clearing pass, main memory keeps its
// contents and must be loaded before it is fetched
// stall: while m_tready is low the result stays in the output register and
// the update stage holds one more beat; s_tready drops until it moves on
// a fetched zero word halts the core until reset; loads are still taken
module multicycle_risc_core #(
    parameter int MEM_WORDS = mrc_pkg::MEM_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] load_address, [41:10] load_word, [47:42] zero
    input  logic [mrc_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] state_after, [13:4] program_counter, [14] halted,
    // [15] reg_write_done, [20:16] reg_written, [52:21] reg_value,
    // [53] mem_write_done, [63:54] mem_address, [95:64] mem_value
    output logic [mrc_pkg::OUT_DATA_W-1:0] m_tdata
);

    import mrc_pkg::*;

    localparam int ADDR_W = $clog2(MEM_WORDS);

    // architectural state as the access stage sees it
    arch_t             eff;
    logic [ADDR_W-1:0] eff_pc;

    logic        accept;
    logic        commit;
    logic        tick_live;
    logic [4:0]  rs_f;
    logic [4:0]  rt_f;
    logic [4:0]  rd_f;
    logic [31:0] load_addr_ext;

    // memory port
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;
    logic [31:0]       mem_addr_ext;

    // register file ports
    logic        rf_re;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic [31:0] rf_a;
    logic [31:0] rf_b;

    // update stage
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic        s2_active_reg;
    logic        s2_rw_reg;
    logic [4:0]  s2_rn_reg;
    logic [31:0] s2_rv_reg;
    logic        s2_mw_reg;
    logic [9:0]  s2_ma_reg;
    logic [31:0] s2_mv_reg;

    // output register
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [31:0]           pc_ext;

    assign commit   = s2_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready = aresetn & (~s2_valid_reg | commit);
    assign accept   = s_tvalid & s_tready;

    // a tick does nothing once halted
    assign tick_live = s_tuser & ~eff.halt;
    assign rs_f      = eff.ir[25:21];
    assign rt_f      = eff.ir[20:16];
    assign rd_f      = eff.ir[15:11];

    assign load_addr_ext = {22'd0, s_tdata[9:0]};

    // memory: load beats and stores write, fetch and memory read read
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = eff.alu[ADDR_W-1:0];
        mem_wdata = eff.opb;
        if (!s_tuser) begin
            mem_en    = accept;
            mem_we    = 1'b1;
            mem_addr  = load_addr_ext[ADDR_W-1:0];
            mem_wdata = s_tdata[41:10];
        end else if (tick_live) begin
            case (eff.fsm)
                ST_FETCH: begin
                    mem_en   = accept;
                    mem_addr = eff_pc;
                end
                ST_MEMRD: begin
                    mem_en = accept;
                end
                ST_MEMWR: begin
                    mem_en = accept;
                    mem_we = 1'b1;
                end
                default: begin
                    mem_en = 1'b0;
                end
            endcase
        end
    end

    assign mem_addr_ext = {{(32 - ADDR_W){1'b0}}, mem_addr};

    // register file: decode reads, the two write-back states write
    always_comb begin
        rf_re = 1'b0;
        rf_we = 1'b0;
        rf_wa = rd_f;
        rf_wd = eff.alu;
        if (accept && tick_live) begin
            case (eff.fsm)
                ST_DECODE: begin
                    rf_re = 1'b1;
                end
                ST_LWB: begin
                    rf_we = (rt_f != 5'd0);
                    rf_wa = rt_f;
                    rf_wd = eff.mdr;
                end
                ST_RWB: begin
                    rf_we = (rd_f != 5'd0);
                end
                default: begin
                    rf_we = 1'b0;
                end
            endcase
        end
    end

    mrc_main_mem #(
        .MEM_WORDS (MEM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mrc_regfile u_rf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (rf_re),
        .ra      (rs_f),
        .rb      (rt_f),
        .we      (rf_we),
        .wa      (rf_wa),
        .wd      (rf_wd),
        .rd_a    (rf_a),
        .rd_b    (rf_b)
    );

    mrc_datapath #(
        .ADDR_W (ADDR_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (commit),
        .active    (s2_active_reg),
        .mem_rdata (mem_rdata),
        .rf_a      (rf_a),
        .rf_b      (rf_b),
        .eff       (eff),
        .eff_pc    (eff_pc)
    );

    assign s2_valid_next = accept | (s2_valid_reg & ~commit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s2_active_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            if (accept) begin
                s2_active_reg <= tick_live;
            end else if (commit) begin
                s2_active_reg <= 1'b0;
            end
        end
    end

    // write reports travel with the beat; zero when nothing was written
    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_rw_reg <= rf_we;
            s2_rn_reg <= rf_we ? rf_wa : 5'd0;
            s2_rv_reg <= rf_we ? rf_wd : 32'd0;
            s2_mw_reg <= mem_en & mem_we & s_tuser;
            s2_ma_reg <= (mem_en & mem_we & s_tuser) ? mem_addr_ext[9:0] : 10'd0;
            s2_mv_reg <= (mem_en & mem_we & s_tuser) ? mem_wdata : 32'd0;
        end
    end

    assign pc_ext       = {{(32 - ADDR_W){1'b0}}, eff_pc};
    assign m_valid_next = commit | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {s2_mv_reg, s2_ma_reg, s2_mw_reg, s2_rv_reg, s2_rn_reg,
                           s2_rw_reg, eff.halt, pc_ext[9:0], state_num(eff.fsm)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/mrc_checker.sv
`timescale 1ns / 1ps

module mrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an accepted beat, with the sink ready after it, yields a result beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result beat missing after accepted beat");

    // a halted core sits in fetch
    a_halt_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[3:0] == 4'd0)
        else $error("halted core not in fetch state");

    // register zero is never reported written, and no beat writes both stores
    a_write_rpt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tdata[20:16] != 5'd0 && !m_tdata[53])
        else $error("bad register write report");

endmodule

bind multicycle_risc_core mrc_checker u_checker (.*);
